// File: rtl/dopct_pkg.sv
package dopct_pkg;

  localparam int MAX_CHANNELS_DEF     = 4;
  localparam int MAX_BANKS_DEF        = 16;
  localparam int QUEUE_ENTRIES_DEF    = 16;
  localparam int LINE_OFFSET_BITS_DEF = 6;

  localparam int ADDR_W  = 48;
  localparam int CYC_W   = 48;
  localparam int ID_W    = 32;
  localparam int LAT_W   = 32;
  localparam int CFG_W   = 8;
  localparam int CFG_A_W = 3;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PG_EMPTY    = 2'd0,
    PG_HIT      = 2'd1,
    PG_CONFLICT = 2'd2,
    PG_RESERVED = 2'd3
  } page_t;

  typedef enum logic [2:0] {
    CFG_CHANNELS  = 3'd0,
    CFG_BANKS     = 3'd1,
    CFG_QLIMIT    = 3'd2,
    CFG_CAS_RD    = 3'd3,
    CFG_CAS_WR    = 3'd4,
    CFG_BURST     = 3'd5,
    CFG_ACTIVATE  = 3'd6,
    CFG_PRECHARGE = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_LOOKUP, S_CALC, S_SUM, S_COMMIT, S_REJECT, S_DRAIN
  } state_t;

  typedef struct packed {
    logic [CYC_W-1:0] done;
    logic [CYC_W-1:0] submit;
    logic [ID_W-1:0]  id;
    page_t            outcome;
    logic             wr;
  } slot_entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  function automatic logic [2:0] floor_log2(input logic [4:0] n);
    logic [2:0] b;
    b = 3'd0;
    for (int i = 1; i < 5; i++) begin
      if (n[i]) b = 3'(i);
    end
    return b;
  endfunction

endpackage

// File: rtl/dopct_cell.sv
module dopct_cell
  import dopct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  slot_entry_t new_entry,
  input  logic        prev_valid,
  input  slot_entry_t prev_entry,
  input  logic        prev_keep,
  input  logic        next_valid,
  input  slot_entry_t next_entry,
  output logic        valid,
  output slot_entry_t entry,
  output logic        keep
);

  // stays put on insert when it sorts ahead of the new entry (done, then id)
  assign keep = valid && ((entry.done < new_entry.done) ||
                ((entry.done == new_entry.done) && (entry.id < new_entry.id)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= next_valid;
    end else if (ctl.ins && !keep) begin
      valid <= prev_keep ? 1'b1 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      entry <= next_entry;
    end else if (ctl.ins && !keep) begin
      entry <= prev_keep ? new_entry : prev_entry;
    end
  end

endmodule

// File: rtl/dopct_bank_mem.sv
module dopct_bank_mem
  import dopct_pkg::*;
#(
  parameter int DEPTH = MAX_CHANNELS_DEF * MAX_BANKS_DEF,
  parameter int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [CYC_W-1:0] wr_free,
  input  logic [ID_W-1:0]  wr_row,
  output logic [CYC_W-1:0] rd_free,
  output logic [ID_W-1:0]  rd_row
);

  logic [CYC_W+ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= {wr_free, wr_row};
    {rd_free, rd_row} <= mem[addr];
  end

endmodule

// File: rtl/dram_open_page_completion_tracker.sv
// channel | dir | transfer                                  | payload
// s_axis  | in  | one request or tick                       | tuser req_type, tdata address
// m_axis  | out | reply or completion, tlast on last result | tuser result_kind, tdata rest
// cfg     | in  | register write, one per cycle             | cfg_addr index, cfg_wdata
// A read or write steps through decode, lookup, calc, sum and commit; a rejected one goes from decode to reject.
// A tick emits each due completion from the head in turn; pending entries sit in a sorted
// chain of slot cells, so the head is always the next due one.
// Bank state is a RAM with registered read; row-valid bits are flops cleared by rst.
// A stalled m_axis holds the sequencer in its emitting state.
module dram_open_page_completion_tracker
  import dopct_pkg::*;
#(
  parameter int MAX_CHANNELS     = MAX_CHANNELS_DEF,
  parameter int MAX_BANKS        = MAX_BANKS_DEF,
  parameter int QUEUE_ENTRIES    = QUEUE_ENTRIES_DEF,
  parameter int LINE_OFFSET_BITS = LINE_OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,  // address
  input  logic [1:0]         s_axis_tuser,  // req_type
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status, id, done_cycle, page_outcome, latency, was_write, pad
  output logic [119:0]       m_axis_tdata,
  output logic               m_axis_tuser,  // result_kind
  output logic               m_axis_tlast,  // last_of_run
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int BANK_TOTAL = MAX_CHANNELS * MAX_BANKS;
  localparam int BW         = $clog2(BANK_TOTAL) > 0 ? $clog2(BANK_TOTAL) : 1;
  localparam int CNT_W      = $clog2(QUEUE_ENTRIES + 1);
  localparam int A_W        = ADDR_W - LINE_OFFSET_BITS;

  // configuration
  logic [2:0] channel_count;
  logic [4:0] bank_count, queue_limit;
  logic [7:0] cas_rd, cas_wr, burst, t_rcd, t_rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 3'd1;
      bank_count    <= 5'd8;
      queue_limit   <= 5'd0;
      cas_rd        <= 8'd14;
      cas_wr        <= 8'd10;
      burst         <= 8'd4;
      t_rcd         <= 8'd14;
      t_rp          <= 8'd14;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_CHANNELS:  channel_count <= cfg_wdata[2:0];
        CFG_BANKS:     bank_count    <= cfg_wdata[4:0];
        CFG_QLIMIT:    queue_limit   <= cfg_wdata[4:0];
        CFG_CAS_RD:    cas_rd        <= cfg_wdata;
        CFG_CAS_WR:    cas_wr        <= cfg_wdata;
        CFG_BURST:     burst         <= cfg_wdata;
        CFG_ACTIVATE:  t_rcd         <= cfg_wdata;
        CFG_PRECHARGE: t_rp          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic [CYC_W-1:0] cycle_now;
  logic [ID_W-1:0]  next_id;
  logic [CNT_W-1:0] pending;
  logic [47:0]      addr_r;
  logic             wr_r;
  logic [BW-1:0]    idx;
  logic [ID_W-1:0]  row;
  status_t          rej_status;
  logic             reject;
  logic [CYC_W-1:0] start;
  logic [9:0]       lat;
  page_t            outcome;
  logic [CYC_W-1:0] done;
  logic [BANK_TOTAL-1:0] row_valid;

  logic [CYC_W-1:0] rd_free;
  logic [ID_W-1:0]  rd_row;

  // slot chain
  logic        c_valid [QUEUE_ENTRIES];
  slot_entry_t c_entry [QUEUE_ENTRIES];
  logic        c_keep  [QUEUE_ENTRIES];
  logic [QUEUE_ENTRIES-1:0] valid_vec;
  cell_ctl_t   ctl;
  slot_entry_t new_entry;

  assign new_entry = '{done: done, submit: cycle_now, id: next_id, outcome: outcome, wr: wr_r};

  for (genvar g = 0; g < QUEUE_ENTRIES; g++) begin : g_cell
    logic        pv, pk, nv;
    slot_entry_t pe, ne;
    if (g == 0) begin : g_first
      assign pv = 1'b0;
      assign pk = 1'b1;
      assign pe = new_entry;
    end else begin : g_mid
      assign pv = c_valid[g-1];
      assign pk = c_keep[g-1];
      assign pe = c_entry[g-1];
    end
    if (g == QUEUE_ENTRIES - 1) begin : g_last
      assign nv = 1'b0;
      assign ne = c_entry[g];
    end else begin : g_inner
      assign nv = c_valid[g+1];
      assign ne = c_entry[g+1];
    end
    dopct_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .new_entry(new_entry),
      .prev_valid(pv), .prev_entry(pe), .prev_keep(pk),
      .next_valid(nv), .next_entry(ne),
      .valid(c_valid[g]), .entry(c_entry[g]), .keep(c_keep[g])
    );
    assign valid_vec[g] = c_valid[g];
  end

  logic mem_we;
  dopct_bank_mem #(.DEPTH(BANK_TOTAL), .AW(BW)) u_bank (
    .clk(clk), .we(mem_we), .addr(idx), .wr_free(done), .wr_row(row),
    .rd_free(rd_free), .rd_row(rd_row)
  );

  // decode of the held address
  logic [2:0]     cbits, bbits;
  logic [A_W-1:0] a_line, a_bank, a_row;
  logic [2:0]     ch_d;
  logic [4:0]     bk_d;
  logic           full_d, range_d;

  always_comb begin
    cbits  = floor_log2({2'b00, channel_count});
    bbits  = floor_log2(bank_count);
    a_line = A_W'(addr_r >> LINE_OFFSET_BITS);
    ch_d   = 3'(a_line & ((A_W'(1) << cbits) - A_W'(1)));
    a_bank = a_line >> cbits;
    bk_d   = 5'(a_bank & ((A_W'(1) << bbits) - A_W'(1)));
    a_row  = a_bank >> bbits;
    full_d = ((queue_limit != 5'd0) && (32'(pending) >= 32'(queue_limit)))
             || c_valid[QUEUE_ENTRIES-1];
    range_d = (ch_d >= channel_count) || (32'(ch_d) >= MAX_CHANNELS) ||
              (bk_d >= bank_count) || (32'(bk_d) >= MAX_BANKS);
  end

  // drain view of the head
  logic             head_due, more_due, out_free;
  logic [CYC_W-1:0] head_span;
  logic [LAT_W-1:0] head_lat;

  assign head_due  = c_valid[0] && (c_entry[0].done <= cycle_now);
  assign more_due  = c_valid[1] && (c_entry[1].done <= cycle_now);
  assign head_span = c_entry[0].done - c_entry[0].submit;
  assign head_lat  = (|head_span[CYC_W-1:LAT_W]) ? '1 : head_span[LAT_W-1:0];
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_xfer) begin
          unique case (req_type_t'(s_axis_tuser))
            REQ_READ, REQ_WRITE: state_next = S_DECODE;
            REQ_TICK:            state_next = S_DRAIN;
            REQ_NONE:            state_next = S_IDLE;
          endcase
        end
      end
      S_DECODE: state_next = (full_d || range_d) ? S_REJECT : S_LOOKUP;
      S_LOOKUP: state_next = S_CALC;
      S_CALC:   state_next = S_SUM;
      S_SUM:    state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      S_REJECT: if (out_free) state_next = S_IDLE;
      S_DRAIN:  if (!head_due) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  logic emit_reply, emit_reject, emit_done;
  always_comb begin
    emit_reply  = (state == S_COMMIT) && out_free;
    emit_reject = (state == S_REJECT) && out_free;
    emit_done   = (state == S_DRAIN) && head_due && out_free;
    mem_we      = emit_reply;
    ctl.ins     = emit_reply;
    ctl.pop     = emit_done;
  end

  // output register
  logic             o_kind, o_wr, o_last;
  status_t          o_status;
  logic [ID_W-1:0]  o_id;
  logic [CYC_W-1:0] o_done;
  page_t            o_outcome;
  logic [LAT_W-1:0] o_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_reply || emit_reject || emit_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_reply || emit_reject) begin
      o_kind    <= 1'b0;
      o_status  <= emit_reply ? ST_OK : rej_status;
      o_id      <= emit_reply ? next_id : '0;
      o_done    <= emit_reply ? done : '0;
      o_outcome <= emit_reply ? outcome : PG_EMPTY;
      o_lat     <= '0;
      o_wr      <= wr_r;
      o_last    <= 1'b1;
    end else if (emit_done) begin
      o_kind    <= 1'b1;
      o_status  <= ST_OK;
      o_id      <= c_entry[0].id;
      o_done    <= c_entry[0].done;
      o_outcome <= c_entry[0].outcome;
      o_lat     <= head_lat;
      o_wr      <= c_entry[0].wr;
      o_last    <= !more_due;
    end
  end

  assign m_axis_tdata = {3'b000, o_wr, o_lat, o_outcome, o_done, o_id, o_status};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cycle_now <= '0;
      next_id   <= ID_W'(1);
      pending   <= '0;
      row_valid <= '0;
    end else begin
      state <= state_next;
      if (s_xfer && (req_type_t'(s_axis_tuser) == REQ_TICK)) cycle_now <= cycle_now + 1'b1;
      if (emit_reply) begin
        next_id        <= next_id + 1'b1;
        row_valid[idx] <= 1'b1;
      end
      if (emit_reply) pending <= pending + 1'b1;
      else if (emit_done) pending <= pending - 1'b1;
    end
  end

  // request datapath
  logic [9:0] cas_sum, lat_c;
  always_comb begin
    cas_sum = 10'(wr_r ? cas_wr : cas_rd) + 10'(burst);
    lat_c   = cas_sum;
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      addr_r <= s_axis_tdata;
      wr_r   <= (req_type_t'(s_axis_tuser) == REQ_WRITE);
    end
    if (state == S_DECODE) begin
      idx        <= BW'(32'(ch_d) * MAX_BANKS + 32'(bk_d));
      row        <= ID_W'(a_row);
      reject     <= full_d || range_d;
      rej_status <= full_d ? ST_FULL : ST_RANGE;
    end
    if (state == S_CALC) begin
      start <= (row_valid[idx] && (rd_free > cycle_now)) ? rd_free : cycle_now;
      priority if (!row_valid[idx]) begin
        outcome <= PG_EMPTY;
        lat     <= (lat_c + 10'(t_rcd) == 10'd0) ? 10'd1 : lat_c + 10'(t_rcd);
      end else if (rd_row == row) begin
        outcome <= PG_HIT;
        lat     <= (lat_c == 10'd0) ? 10'd1 : lat_c;
      end else begin
        outcome <= PG_CONFLICT;
        lat     <= (lat_c + 10'(t_rcd) + 10'(t_rp) == 10'd0) ? 10'd1
                   : lat_c + 10'(t_rcd) + 10'(t_rp);
      end
    end
    if (state == S_SUM) done <= start + CYC_W'(lat);
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    32'(pending) == $countones(valid_vec))
    else $error("pending count out of step with slot cells");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pending) <= QUEUE_ENTRIES)
    else $error("pending count above capacity");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    (state == S_REJECT) |-> reject)
    else $error("reject path without a failed check");

endmodule
